// ===== hw/rtl/grid_region_live_entity_query_defines.svh =====
// Assertion macros shared by the live-entity query block.
// Included by the modules that carry concurrent checks; no dependencies.
`ifndef GRID_REGION_LIVE_ENTITY_QUERY_DEFINES_SVH
`define GRID_REGION_LIVE_ENTITY_QUERY_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define GRQ_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define GRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== hw/rtl/grq_pkg.sv =====
// Shared types and constants of the live-entity query block.
// No dependencies.
package grq_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_DEFEAT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_REGION   = 2'd1,
    FAULT_CAPACITY = 2'd2,
    FAULT_ORDINAL  = 2'd3
  } fault_e;

  localparam logic CFG_PLAN_READY   = 1'b0;
  localparam logic CFG_ENTITY_TOTAL = 1'b1;

  // One classified item as it passes from the front to the back.
  typedef struct packed {
    logic       is_query;
    logic       refused;
    logic [3:0] col_lo;
    logic [3:0] col_hi;
    logic [3:0] row_lo;
    logic [3:0] row_hi;
  } grq_cmd_t;

endpackage

// ===== hw/rtl/grq_front.sv =====
// Front part: accepts items, does loads and defeats, classifies queries.
// Depends on grq_pkg; includes the assertion macro header.
`include "grid_region_live_entity_query_defines.svh"
module grq_front #(
  parameter int GridColumns = 8,
  parameter int GridRows    = 8,
  parameter int MaxEntities = 256,
  parameter int CellAw      = 7,
  parameter int FlagAw      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        mode_i,
  input  logic [6:0]        cell_index_i,
  input  logic [8:0]        offset_value_i,
  input  logic [7:0]        entity_ordinal_i,
  input  logic [3:0]        first_column_i,
  input  logic [3:0]        column_span_i,
  input  logic [3:0]        first_row_i,
  input  logic [3:0]        row_span_i,
  input  logic              plan_ready_i,
  input  logic [8:0]        total_i,
  input  logic              walk_i,
  input  logic [FlagAw-1:0] walk_addr_i,
  output logic              busy_o,
  output logic              flag_rd_o,
  output logic              tab_we_o,
  output logic [CellAw-1:0] tab_waddr_o,
  output logic [8:0]        tab_wdata_o,
  output logic              cmd_valid_o,
  output grq_pkg::grq_cmd_t cmd_o,
  output logic              simple_valid_o,
  output logic [1:0]        simple_fault_o,
  output logic              simple_newly_o,
  output logic [8:0]        defeated_total_o
);
  import grq_pkg::*;

  localparam int CellCount = GridColumns * GridRows;

  logic              flag_mem [0:MaxEntities-1];
  logic              flag_rd_q;
  logic [FlagAw-1:0] flag_raddr;
  logic              flag_we;
  logic              pend_q, pend_ok_q;
  logic [FlagAw-1:0] pend_ord_q;
  logic              clr_q;
  logic [FlagAw-1:0] clr_idx_q;
  logic [8:0]        count_q;
  logic              take;
  logic [4:0]        col_end, row_end;
  logic              ord_ok;

  assign take    = start_i && !busy_i;
  assign col_end = {1'b0, first_column_i} + {1'b0, column_span_i};
  assign row_end = {1'b0, first_row_i} + {1'b0, row_span_i};
  assign ord_ok  = plan_ready_i && ({1'b0, entity_ordinal_i} < total_i);

  // Offset table write for a load item within range.
  assign tab_we_o    = take && (mode_i == MODE_LOAD) && ({25'd0, cell_index_i} <= CellCount);
  assign tab_waddr_o = CellAw'(cell_index_i);
  assign tab_wdata_o = offset_value_i;

  // The back walks the flags while it is active; otherwise a defeat reads its own flag.
  assign flag_raddr = walk_i ? walk_addr_i : entity_ordinal_i[FlagAw-1:0];
  assign flag_we    = pend_q && pend_ok_q && !flag_rd_q;
  assign flag_rd_o  = flag_rd_q;
  assign busy_o     = clr_q || pend_q;

  // Defeated flag memory: cleared by a pass after reset, one registered read.
  always_ff @(posedge clk_i) begin
    if (clr_q) flag_mem[clr_idx_q] <= 1'b0;
    else if (flag_we) flag_mem[pend_ord_q] <= 1'b1;
    flag_rd_q <= flag_mem[flag_raddr];
  end

  // Clearing pass, pending defeat and the defeated counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_idx_q  <= '0;
      pend_q     <= 1'b0;
      pend_ok_q  <= 1'b0;
      pend_ord_q <= '0;
      count_q    <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == FlagAw'(MaxEntities - 1)) clr_q <= 1'b0;
      end
      pend_q <= take && (mode_i == MODE_DEFEAT);
      if (take) begin
        pend_ok_q  <= ord_ok;
        pend_ord_q <= entity_ordinal_i[FlagAw-1:0];
      end
      if (flag_we) count_q <= count_q + 9'd1;
    end
  end
  assign defeated_total_o = count_q;

  // Single-result items and the query command.
  always_comb begin
    simple_valid_o = (take && (mode_i == MODE_LOAD || mode_i == MODE_NONE)) || pend_q;
    simple_newly_o = flag_we;
    simple_fault_o = (pend_q && !pend_ok_q) ? FAULT_ORDINAL : FAULT_NONE;
    cmd_valid_o    = take && (mode_i == MODE_QUERY);
    cmd_o.is_query = 1'b1;
    cmd_o.refused  = !plan_ready_i || column_span_i == 4'd0 || row_span_i == 4'd0 ||
                     {27'd0, col_end} > GridColumns || {27'd0, row_end} > GridRows;
    cmd_o.col_lo   = first_column_i;
    cmd_o.col_hi   = 4'(col_end - 5'd1);
    cmd_o.row_lo   = first_row_i;
    cmd_o.row_hi   = 4'(row_end - 5'd1);
  end

  `GRQ_ASSERT(a_one_kind, take, !(cmd_valid_o && simple_valid_o))
  `GRQ_ASSERT_NEXT(a_count_step, flag_we, count_q == $past(count_q) + 9'd1)
  `GRQ_ASSERT(a_no_load_busy, busy_i, !tab_we_o)
  `GRQ_ASSERT(a_flag_pending, flag_we, pend_q)
endmodule

// ===== hw/rtl/grq_back.sv =====
// Back part: walks the region, gathers, sorts and emits live ordinals.
// Depends on grq_pkg; includes the assertion macro header.
`include "grid_region_live_entity_query_defines.svh"
module grq_back #(
  parameter int GridColumns  = 8,
  parameter int MaxEntities  = 256,
  parameter int MaxResidents = 32,
  parameter int CellAw       = 7,
  parameter int FlagAw       = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  grq_pkg::grq_cmd_t cmd_i,
  output logic              active_o,
  input  logic              tab_we_i,
  input  logic [CellAw-1:0] tab_waddr_i,
  input  logic [8:0]        tab_wdata_i,
  input  logic [8:0]        total_i,
  output logic [FlagAw-1:0] walk_addr_o,
  input  logic              flag_i,
  output logic              res_valid_o,
  output logic              res_has_o,
  output logic [7:0]        res_ord_o,
  output logic              res_last_o,
  output logic [1:0]        res_fault_o
);
  import grq_pkg::*;

  localparam int CntW = $clog2(MaxResidents + 1);
  localparam int IdxW = (MaxResidents > 1) ? $clog2(MaxResidents) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDA   = 7'b0000010,
    S_RDB   = 7'b0000100,
    S_RUN   = 7'b0001000,
    S_SORT  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_FAULT = 7'b1000000
  } state_e;

  state_e state_q;
  logic [8:0] table_q [0:(1<<CellAw)-1];
  logic [8:0] rd_q;
  logic [8:0] begin_q, end_q, ord_q;
  logic [CellAw-1:0] raddr;
  logic [3:0] col_q, row_q;
  grq_cmd_t cmd_q;
  logic [7:0] buf_q [0:MaxResidents-1];
  logic [CntW-1:0] cnt_q, pos_q;
  logic [1:0] fault_q;
  logic pass_q, look_q, swapped_q, dup_q;
  logic [CellAw-1:0] cell_idx;
  logic [IdxW-1:0] p0, p1, pe;

  assign cell_idx = CellAw'({3'd0, row_q} * GridColumns[CellAw-1:0] + {3'd0, col_q});
  assign raddr = (state_q == S_RDA) ? cell_idx : CellAw'(cell_idx + 1'b1);
  assign p0 = IdxW'(pos_q);
  assign p1 = IdxW'(pos_q + 1'b1);
  assign pe = IdxW'(pos_q);
  assign walk_addr_o = ord_q[FlagAw-1:0];

  // Offset table memory; one write port, one registered read.
  always_ff @(posedge clk_i) begin
    if (tab_we_i) table_q[tab_waddr_i] <= tab_wdata_i;
    rd_q <= table_q[raddr];
  end

  assign active_o = (state_q != S_IDLE);

  // Sequencer: read both offsets of each cell, walk its run, then bubble sort and emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      pos_q <= '0;
      fault_q <= FAULT_NONE;
      pass_q <= 1'b0;
      look_q <= 1'b0;
      swapped_q <= 1'b0;
      dup_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            col_q <= cmd_i.col_lo;
            row_q <= cmd_i.row_lo;
            cnt_q <= '0;
            dup_q <= 1'b0;
            fault_q <= FAULT_REGION;
            state_q <= cmd_i.refused ? S_FAULT : S_RDA;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          begin_q <= rd_q;
          state_q <= S_RUN;
          pass_q <= 1'b0;
          look_q <= 1'b0;
        end
        S_RUN: begin
          if (!pass_q) begin
            end_q <= rd_q;
            ord_q <= begin_q;
            pass_q <= 1'b1;
            if (begin_q > rd_q || rd_q > total_i) begin
              fault_q <= FAULT_REGION;
              state_q <= S_FAULT;
            end
          end else if (ord_q < end_q) begin
            // The flag of an ordinal is read while look_q is low and judged in the next cycle.
            look_q <= !look_q;
            if (look_q) begin
              ord_q <= ord_q + 9'd1;
              if (!flag_i) begin
                if ({{(32-CntW){1'b0}}, cnt_q} >= MaxResidents) begin
                  fault_q <= FAULT_CAPACITY;
                  state_q <= S_FAULT;
                end else begin
                  buf_q[IdxW'(cnt_q)] <= ord_q[7:0];
                  cnt_q <= cnt_q + 1'b1;
                end
              end
            end
          end else if (col_q != cmd_q.col_hi) begin
            col_q <= col_q + 4'd1;
            state_q <= S_RDA;
          end else if (row_q != cmd_q.row_hi) begin
            row_q <= row_q + 4'd1;
            col_q <= cmd_q.col_lo;
            state_q <= S_RDA;
          end else begin
            pos_q <= '0;
            swapped_q <= 1'b0;
            state_q <= S_SORT;
          end
        end
        S_SORT: begin
          // One compare-exchange a cycle; passes repeat until none swaps.
          if (cnt_q < 2 || pos_q + 1'b1 >= cnt_q) begin
            pos_q <= '0;
            swapped_q <= 1'b0;
            if (!swapped_q || cnt_q < 2) begin
              if (dup_q) begin
                fault_q <= FAULT_REGION;
                state_q <= S_FAULT;
              end else begin
                fault_q <= FAULT_NONE;
                state_q <= (cnt_q == '0) ? S_FAULT : S_EMIT;
              end
            end else begin
              dup_q <= 1'b0;
            end
          end else begin
            pos_q <= pos_q + 1'b1;
            if (buf_q[p0] > buf_q[p1]) begin
              buf_q[p0] <= buf_q[p1];
              buf_q[p1] <= buf_q[p0];
              swapped_q <= 1'b1;
            end else if (buf_q[p0] == buf_q[p1]) begin
              dup_q <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          pos_q <= pos_q + 1'b1;
          if (pos_q + 1'b1 == cnt_q) state_q <= S_IDLE;
        end
        S_FAULT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_EMIT) || (state_q == S_FAULT);
  assign res_has_o   = (state_q == S_EMIT);
  assign res_ord_o   = (state_q == S_EMIT) ? buf_q[pe] : 8'd0;
  assign res_last_o  = (state_q == S_FAULT) || (pos_q + 1'b1 == cnt_q);
  assign res_fault_o = (state_q == S_EMIT) ? FAULT_NONE : fault_q;

  `GRQ_ASSERT(a_emit_nonempty, state_q == S_EMIT, cnt_q != '0)
  `GRQ_ASSERT(a_emit_clean, state_q == S_EMIT, fault_q == FAULT_NONE)
  `GRQ_ASSERT_NEXT(a_fault_single, state_q == S_FAULT, state_q == S_IDLE)
endmodule

// ===== hw/rtl/grid_region_live_entity_query.sv =====
// Top level of the live-entity region query block.
// Depends on grq_pkg, grq_front and grq_back.
//
// Channel  | Ports                                      | Handshake
// input    | mode_i .. row_span_i                       | start high, busy low
// result   | has_ordinal_o .. defeated_total_o          | done_o high with each beat
// config   | cfg_we_i, cfg_index_i, cfg_wdata_i         | write enable, no wait
//
// After reset a pass over all MAX_ENTITIES flags clears them; busy is high
// throughout. Loads and mode 3 give their result in the cycle after acceptance;
// a defeat reads its flag into a pending register, then gives its result, with
// busy high in between. A query reads both offsets of each cell, reads and
// judges the flag of each entity in the runs, bubble-sorts the gathered
// ordinals and gives one beat per ordinal; busy is high throughout. A refused
// query gives its single result in the cycle after acceptance. Results cannot
// be stalled. The offset table is undefined until loaded.
module grid_region_live_entity_query #(
  parameter int GRID_COLUMNS  = 8,
  parameter int GRID_ROWS     = 8,
  parameter int MAX_ENTITIES  = 256,
  parameter int MAX_RESIDENTS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] mode_i,
  input  logic [6:0] cell_index_i,
  input  logic [8:0] offset_value_i,
  input  logic [7:0] entity_ordinal_i,
  input  logic [3:0] first_column_i,
  input  logic [3:0] column_span_i,
  input  logic [3:0] first_row_i,
  input  logic [3:0] row_span_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_wdata_i,
  output logic       done_o,
  output logic       has_ordinal_o,
  output logic [7:0] ordinal_out_o,
  output logic       last_o,
  output logic [1:0] fault_code_o,
  output logic       newly_defeated_o,
  output logic [8:0] living_total_o,
  output logic [8:0] defeated_total_o
);
  import grq_pkg::*;

  localparam int CellAw = $clog2(GRID_COLUMNS * GRID_ROWS + 1);
  localparam int FlagAw = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;

  logic       plan_ready_q;
  logic [8:0] entity_total_q, total;
  logic       tab_we, cmd_valid, simple_valid, simple_newly, active;
  logic       front_busy, flag_rd;
  logic [FlagAw-1:0] walk_addr;
  logic [CellAw-1:0] tab_waddr;
  logic [8:0] tab_wdata, dcount;
  logic [1:0] simple_fault;
  grq_cmd_t   cmd;
  logic       sv_q, sn_q;
  logic [1:0] sf_q;
  logic       bv, bh, bl;
  logic [7:0] bo;
  logic [1:0] bf;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_ready_q   <= 1'b0;
      entity_total_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PLAN_READY) plan_ready_q <= cfg_wdata_i[0];
      else entity_total_q <= cfg_wdata_i;
    end
  end
  assign total = ({23'd0, entity_total_q} > MAX_ENTITIES) ? 9'(MAX_ENTITIES) : entity_total_q;

  grq_front #(.GridColumns(GRID_COLUMNS), .GridRows(GRID_ROWS),
              .MaxEntities(MAX_ENTITIES), .CellAw(CellAw), .FlagAw(FlagAw)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .mode_i, .cell_index_i, .offset_value_i, .entity_ordinal_i,
    .first_column_i, .column_span_i, .first_row_i, .row_span_i,
    .plan_ready_i(plan_ready_q), .total_i(total),
    .walk_i(active), .walk_addr_i(walk_addr), .busy_o(front_busy), .flag_rd_o(flag_rd),
    .tab_we_o(tab_we), .tab_waddr_o(tab_waddr), .tab_wdata_o(tab_wdata),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .simple_valid_o(simple_valid), .simple_fault_o(simple_fault),
    .simple_newly_o(simple_newly), .defeated_total_o(dcount)
  );

  grq_back #(.GridColumns(GRID_COLUMNS), .MaxEntities(MAX_ENTITIES),
             .MaxResidents(MAX_RESIDENTS), .CellAw(CellAw), .FlagAw(FlagAw)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .active_o(active),
    .tab_we_i(tab_we), .tab_waddr_i(tab_waddr), .tab_wdata_i(tab_wdata),
    .total_i(total), .walk_addr_o(walk_addr), .flag_i(flag_rd),
    .res_valid_o(bv), .res_has_o(bh), .res_ord_o(bo), .res_last_o(bl),
    .res_fault_o(bf)
  );

  // Result register for single-beat items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      sn_q <= 1'b0;
      sf_q <= FAULT_NONE;
    end else begin
      sv_q <= simple_valid;
      sn_q <= simple_newly;
      sf_q <= simple_fault;
    end
  end

  assign busy             = active || front_busy;
  assign done_o           = sv_q || bv;
  assign has_ordinal_o    = !sv_q && bh;
  assign ordinal_out_o    = sv_q ? 8'd0 : bo;
  assign last_o           = sv_q || bl;
  assign fault_code_o     = sv_q ? sf_q : bf;
  assign newly_defeated_o = sv_q && sn_q;
  assign defeated_total_o = dcount;
  assign living_total_o   = ((plan_ready_q ? total : 9'd0) >= dcount) ?
                            (plan_ready_q ? total : 9'd0) - dcount : 9'd0;
endmodule

// ===== tb/grid_region_live_entity_query_test.sv =====
// Self-checking testbench for the live-entity region query block.
// Drives command beats, predicts every result beat and checks them in order.
// Depends on grq_pkg and grid_region_live_entity_query.
module grid_region_live_entity_query_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grq_pkg::*;

  localparam int COLS        = 8;
  localparam int ROWS        = 8;
  localparam int CELLS       = COLS * ROWS;
  localparam int ENT_MAX     = 256;
  localparam int RES_MAX     = 32;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic       has;
    logic [7:0] ord;
    logic       last;
    fault_e     fault;
    logic       newly;
    logic [8:0] living;
    logic [8:0] defeated;
  } region_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] mode_i = '0;
  logic [6:0] cell_index_i = '0;
  logic [8:0] offset_value_i = '0;
  logic [7:0] entity_ordinal_i = '0;
  logic [3:0] first_column_i = '0;
  logic [3:0] column_span_i = '0;
  logic [3:0] first_row_i = '0;
  logic [3:0] row_span_i = '0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic       done_o;
  logic       has_ordinal_o;
  logic [7:0] ordinal_out_o;
  logic       last_o;
  logic [1:0] fault_code_o;
  logic       newly_defeated_o;
  logic [8:0] living_total_o;
  logic [8:0] defeated_total_o;

  // Mirror of the block's state.
  logic       plan_ready_m;
  logic [8:0] entity_total_m;
  logic [8:0] cell_start_m [0:CELLS];
  logic [8:0] plan_offsets [0:CELLS];
  logic       defeated_m [0:ENT_MAX-1];
  logic [8:0] defeated_count_m;

  region_beat_t expected_beats[$];
  int           mismatch_count;
  int           quiet_cycles;
  int           sender_idle_pct;

  grid_region_live_entity_query dut (.*);

  always #5ns clk_i = ~clk_i;

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // Compare each result beat with the oldest expected beat.
  always @(posedge clk_i) begin
    region_beat_t e;
    if (rst_ni && done_o) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = expected_beats.pop_front();
        if (has_ordinal_o !== e.has) report_mismatch("has_ordinal", has_ordinal_o, e.has);
        if (ordinal_out_o !== e.ord) report_mismatch("ordinal_out", ordinal_out_o, e.ord);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        if (fault_code_o !== e.fault) report_mismatch("fault_code", fault_code_o, e.fault);
        if (newly_defeated_o !== e.newly)
          report_mismatch("newly_defeated", newly_defeated_o, e.newly);
        if (living_total_o !== e.living)
          report_mismatch("living_total", living_total_o, e.living);
        if (defeated_total_o !== e.defeated)
          report_mismatch("defeated_total", defeated_total_o, e.defeated);
      end
    end
  end

  // Watchdog: too long without any beat moving ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int effective_total();
    return (entity_total_m > ENT_MAX) ? ENT_MAX : int'(entity_total_m);
  endfunction

  function automatic void push_beat(logic has, logic [7:0] ord, logic last, fault_e fault,
                                    logic newly);
    region_beat_t b;
    int total;
    total = plan_ready_m ? effective_total() : 0;
    b.has = has;
    b.ord = ord;
    b.last = last;
    b.fault = fault;
    b.newly = newly;
    b.living = (total >= defeated_count_m) ? 9'(total - defeated_count_m) : 9'd0;
    b.defeated = defeated_count_m;
    expected_beats.push_back(b);
  endfunction

  // Gather, sort and check the live ordinals of one query rectangle.
  function automatic void predict_query(int c0, int cs, int r0, int rs);
    int gathered[$];
    int total;
    int lo;
    int hi;
    total = effective_total();
    if (!plan_ready_m || cs == 0 || rs == 0 || c0 + cs > COLS || r0 + rs > ROWS) begin
      push_beat(1'b0, '0, 1'b1, FAULT_REGION, 1'b0);
      return;
    end
    for (int row = r0; row < r0 + rs; row++) begin
      for (int col = c0; col < c0 + cs; col++) begin
        lo = cell_start_m[row * COLS + col];
        hi = cell_start_m[row * COLS + col + 1];
        if (lo > hi || hi > total) begin
          push_beat(1'b0, '0, 1'b1, FAULT_REGION, 1'b0);
          return;
        end
        for (int o = lo; o < hi; o++) begin
          if (!defeated_m[o]) begin
            if (gathered.size() >= RES_MAX) begin
              push_beat(1'b0, '0, 1'b1, FAULT_CAPACITY, 1'b0);
              return;
            end
            gathered.push_back(o);
          end
        end
      end
    end
    gathered.sort();
    for (int i = 1; i < gathered.size(); i++) begin
      if (gathered[i-1] == gathered[i]) begin
        push_beat(1'b0, '0, 1'b1, FAULT_REGION, 1'b0);
        return;
      end
    end
    if (gathered.size() == 0) begin
      push_beat(1'b0, '0, 1'b1, FAULT_NONE, 1'b0);
      return;
    end
    foreach (gathered[i])
      push_beat(1'b1, 8'(gathered[i]), i == gathered.size() - 1, FAULT_NONE, 1'b0);
  endfunction

  function automatic void predict_item(mode_e m, int idx, int val, int ord,
                                       int c0, int cs, int r0, int rs);
    case (m)
      MODE_LOAD: begin
        if (idx <= CELLS) cell_start_m[idx] = 9'(val);
        push_beat(1'b0, '0, 1'b1, FAULT_NONE, 1'b0);
      end
      MODE_DEFEAT: begin
        if (!plan_ready_m || ord >= effective_total()) begin
          push_beat(1'b0, '0, 1'b1, FAULT_ORDINAL, 1'b0);
        end else if (defeated_m[ord]) begin
          push_beat(1'b0, '0, 1'b1, FAULT_NONE, 1'b0);
        end else begin
          defeated_m[ord] = 1'b1;
          defeated_count_m = defeated_count_m + 9'd1;
          push_beat(1'b0, '0, 1'b1, FAULT_NONE, 1'b1);
        end
      end
      MODE_QUERY: predict_query(c0, cs, r0, rs);
      default: push_beat(1'b0, '0, 1'b1, FAULT_NONE, 1'b0);
    endcase
  endfunction

  // Send one command beat, with a random gap first in the idling phases.
  task automatic send_item(mode_e m, int idx, int val, int ord,
                           int c0, int cs, int r0, int rs);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    while (gap > 0 || busy) begin
      start = 1'b0;
      if (gap > 0) gap--;
      @(negedge clk_i);
    end
    start = 1'b1;
    mode_i = m;
    cell_index_i = 7'(idx);
    offset_value_i = 9'(val);
    entity_ordinal_i = 8'(ord);
    first_column_i = 4'(c0);
    column_span_i = 4'(cs);
    first_row_i = 4'(r0);
    row_span_i = 4'(rs);
    @(posedge clk_i);
    predict_item(m, idx, val, ord, c0, cs, r0, rs);
  endtask

  task automatic load_offset(int idx, int val);
    send_item(MODE_LOAD, idx, val, $urandom_range(255), $urandom_range(15),
              $urandom_range(15), $urandom_range(15), $urandom_range(15));
  endtask

  task automatic defeat(int ord);
    send_item(MODE_DEFEAT, $urandom_range(127), $urandom_range(511), ord,
              $urandom_range(15), $urandom_range(15), $urandom_range(15), $urandom_range(15));
  endtask

  task automatic query(int c0, int cs, int r0, int rs);
    send_item(MODE_QUERY, $urandom_range(127), $urandom_range(511), $urandom_range(255),
              c0, cs, r0, rs);
  endtask

  // Wait until every expected beat has arrived, then a little longer.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_beats.size() != 0 || busy) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_register(logic index, int value);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_wdata_i = 9'(value);
    if (index == CFG_PLAN_READY) plan_ready_m = value[0];
    else entity_total_m = 9'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_plan();
    for (int c = 0; c <= CELLS; c++) load_offset(c, plan_offsets[c]);
  endtask

  // Random nondecreasing offsets that end at or below the given total.
  task automatic make_plan(int total);
    int acc;
    acc = $urandom_range(3);
    for (int c = 0; c <= CELLS; c++) begin
      plan_offsets[c] = 9'((acc > total) ? total : acc);
      acc += $urandom_range(0, 6);
    end
  endtask

  // Refused and ignored commands before any offset is loaded.
  task automatic test_before_plan();
    query(0, 1, 0, 1);
    query(15, 15, 15, 15);
    defeat(0);
    defeat(255);
    send_item(MODE_NONE, 127, 511, 255, 15, 15, 15, 15);
    load_offset(65, 511);
    load_offset(127, 256);
  endtask

  // Extremes of the fields and every fault on an evenly filled grid.
  task automatic test_directed();
    for (int c = 0; c <= CELLS; c++) plan_offsets[c] = 9'(c * 4);
    load_plan();
    write_register(CFG_ENTITY_TOTAL, 256);
    write_register(CFG_PLAN_READY, 1);
    query(0, 1, 0, 1);
    query(7, 1, 7, 1);
    query(0, 8, 0, 8);
    query(0, 0, 0, 1);
    query(0, 1, 0, 0);
    query(7, 2, 0, 1);
    query(15, 15, 15, 15);
    defeat(0);
    defeat(0);
    defeat(255);
    query(0, 1, 0, 1);
    query(7, 1, 7, 1);
    send_item(MODE_NONE, 0, 0, 0, 0, 0, 0, 0);
    // Overlapping runs in cells 0 and 8; the long run of cell 8 overflows the gather buffer.
    load_offset(8, 2);
    query(0, 1, 0, 2);
    // A cell whose start exceeds its end.
    load_offset(8, 40);
    query(0, 1, 0, 2);
    load_offset(8, plan_offsets[8]);
    // Runs beyond a shrunken entity total, and an ordinal beyond it.
    write_register(CFG_ENTITY_TOTAL, 100);
    query(0, 8, 3, 1);
    defeat(150);
    write_register(CFG_ENTITY_TOTAL, 511);
    defeat(255);
  endtask

  // One phase of well-formed traffic with some noise; a fresh plan is loaded on request.
  task automatic test_random_phase(int total, int idle_pct, int items, logic fresh);
    int pick;
    int idx;
    sender_idle_pct = idle_pct;
    if (fresh) begin
      write_register(CFG_PLAN_READY, 0);
      write_register(CFG_ENTITY_TOTAL, total);
      make_plan((total > ENT_MAX) ? ENT_MAX : total);
      load_plan();
      write_register(CFG_PLAN_READY, 1);
    end else begin
      write_register(CFG_ENTITY_TOTAL, total);
    end
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (n == items / 2) drain();
      if (pick < 50) begin
        if ($urandom_range(9) == 0)
          query($urandom_range(15), $urandom_range(15), $urandom_range(15), $urandom_range(15));
        else
          query($urandom_range(7), $urandom_range(1, 3), $urandom_range(7), $urandom_range(1, 3));
      end else if (pick < 80) begin
        defeat($urandom_range(255));
      end else if (pick < 90) begin
        idx = $urandom_range(127);
        load_offset(idx, $urandom_range(511));
        if (idx <= CELLS) begin
          query($urandom_range(7), $urandom_range(1, 2), $urandom_range(7), $urandom_range(1, 2));
          load_offset(idx, plan_offsets[idx]);
        end
      end else begin
        send_item(MODE_NONE, $urandom_range(127), $urandom_range(511), $urandom_range(255),
                  $urandom_range(15), $urandom_range(15), $urandom_range(15),
                  $urandom_range(15));
      end
    end
  endtask

  initial begin
    plan_ready_m = 1'b0;
    entity_total_m = '0;
    defeated_count_m = '0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    foreach (defeated_m[i]) defeated_m[i] = 1'b0;
    foreach (cell_start_m[i]) cell_start_m[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_plan();
    test_directed();
    test_random_phase(256, 0, 15, 1'b0);
    test_random_phase(511, 61, 15, 1'b0);
    test_random_phase($urandom_range(1, 255), 11, 20, 1'b1);
    test_random_phase(0, 61, 10, 1'b0);

    drain();
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
